// ===== rtl/ldm_pkg.sv =====
// Package for the label deficiency mask block: widths and defaults.
`default_nettype none
package ldm_pkg;

  localparam int MASK_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 24;
  localparam int ALPHA_BITS     = 18;
  localparam int FRAC_BITS      = 16;
  localparam int OUT_MASK_BITS  = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int SUM_CAP_BITS   = 64;

endpackage
`default_nettype wire

// ===== rtl/ldm_front.sv =====
// Front end: zero-total handling and cross products for one label transaction.
`default_nettype none
module ldm_front #(
  parameter int COUNT_BITS = ldm_pkg::COUNT_BITS_DEF,
  parameter int PROD_BITS  = 2 * COUNT_BITS,
  parameter int ENTRY_BITS = 3 * PROD_BITS + 1
) (
  input  wire logic [COUNT_BITS-1:0] own_count_i,
  input  wire logic [COUNT_BITS-1:0] other_count_i,
  input  wire logic [COUNT_BITS-1:0] own_total_i,
  input  wire logic [COUNT_BITS-1:0] other_total_i,
  input  wire logic                  last_label_i,
  output logic      [ENTRY_BITS-1:0] entry_o
);
  import ldm_pkg::*;

  logic [COUNT_BITS-1:0] own_cnt, other_cnt, own_tot, other_tot;
  logic [PROD_BITS-1:0]  own_x, other_x, tot_prod;

  // A zero total means all frequencies of that histogram are zero.
  always_comb begin
    own_cnt   = (own_total_i == '0) ? '0 : own_count_i;
    own_tot   = (own_total_i == '0) ? COUNT_BITS'(1) : own_total_i;
    other_cnt = (other_total_i == '0) ? '0 : other_count_i;
    other_tot = (other_total_i == '0) ? COUNT_BITS'(1) : other_total_i;
  end

  assign own_x    = PROD_BITS'(own_cnt) * PROD_BITS'(other_tot);
  assign other_x  = PROD_BITS'(other_cnt) * PROD_BITS'(own_tot);
  assign tot_prod = PROD_BITS'(own_tot) * PROD_BITS'(other_tot);

  assign entry_o = {last_label_i, tot_prod, other_x, own_x};

endmodule
`default_nettype wire

// ===== rtl/ldm_queue.sv =====
// Small queue between front end and back end.
`default_nettype none
module ldm_queue #(
  parameter int ENTRY_BITS = 3 * 2 * ldm_pkg::COUNT_BITS_DEF + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic [ENTRY_BITS-1:0] push_data_i,
  input  wire logic                  pop_i,
  output logic      [ENTRY_BITS-1:0] pop_data_o,
  output logic                       full_o,
  output logic                       empty_o
);
  import ldm_pkg::*;

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [ENTRY_BITS-1:0]     mem_q [QUEUE_DEPTH];
  logic [QUEUE_IDX_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]       count_q, count_d;

  assign full_o     = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ldm_back.sv =====
// Back end: difference, mask and sum accumulation, final alpha test, result register.
`default_nettype none
module ldm_back #(
  parameter int MASK_BITS  = ldm_pkg::MASK_BITS_DEF,
  parameter int COUNT_BITS = ldm_pkg::COUNT_BITS_DEF,
  parameter int PROD_BITS  = 2 * COUNT_BITS,
  parameter int ENTRY_BITS = 3 * PROD_BITS + 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [ldm_pkg::ALPHA_BITS-1:0]      alpha_i,
  input  wire logic [ENTRY_BITS-1:0]               entry_i,
  input  wire logic                                empty_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [ldm_pkg::OUT_MASK_BITS-1:0]   deficiency_mask_o,
  output logic                                     within_alpha_o
);
  import ldm_pkg::*;

  localparam int SUM_BITS = (2 * COUNT_BITS + 2 > SUM_CAP_BITS) ? SUM_CAP_BITS
                                                                : 2 * COUNT_BITS + 2;
  localparam int POS_BITS = $clog2(MASK_BITS + 1);
  localparam int LHS_BITS = SUM_BITS + FRAC_BITS;
  localparam int RHS_BITS = PROD_BITS + ALPHA_BITS;
  localparam int CMP_BITS = (LHS_BITS > RHS_BITS) ? LHS_BITS : RHS_BITS;

  logic                 en;
  logic [PROD_BITS-1:0] e_own_x, e_other_x, e_tot;
  logic                 e_last;

  // stage 1: compare and difference
  logic                 s1_valid_q;
  logic                 s1_gt_q, s1_last_q;
  logic [PROD_BITS-1:0] s1_diff_q, s1_tot_q;

  // stage 2: running state
  logic [POS_BITS-1:0]  pos_q, pos_d;
  logic [MASK_BITS-1:0] mask_q, mask_d;
  logic [SUM_BITS-1:0]  sum_q, sum_d;
  logic [SUM_BITS:0]    sum_wide;
  logic                 fin_valid_q;
  logic [SUM_BITS-1:0]  fin_sum_q;
  logic [MASK_BITS-1:0] fin_mask_q;
  logic [PROD_BITS-1:0] fin_tot_q;

  // stage 3: threshold product
  logic                 s3_valid_q;
  logic [SUM_BITS-1:0]  s3_sum_q;
  logic [MASK_BITS-1:0] s3_mask_q;
  logic [RHS_BITS-1:0]  s3_prod_q;

  logic [CMP_BITS-1:0]  lhs, rhs;
  logic                 proximal;
  logic [OUT_MASK_BITS+MASK_BITS-1:0] mask_ext;

  assign {e_last, e_tot, e_other_x, e_own_x} = entry_i;

  // Whole back end advances together unless a held result blocks it.
  assign en    = !out_valid_o || !out_stall_i;
  assign pop_o = en && !empty_i;

  always_comb begin
    sum_wide = {1'b0, sum_q} + (SUM_BITS + 1)'(s1_diff_q);
    sum_d    = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
    mask_d   = mask_q;
    if (s1_gt_q && (pos_q < POS_BITS'(MASK_BITS))) begin
      mask_d = mask_q | (MASK_BITS'(1) << pos_q);
    end
    pos_d = (pos_q < POS_BITS'(MASK_BITS)) ? pos_q + 1'b1 : pos_q;
  end

  assign lhs      = CMP_BITS'({s3_sum_q, {FRAC_BITS{1'b0}}});
  assign rhs      = CMP_BITS'(s3_prod_q);
  assign proximal = (lhs < rhs);
  assign mask_ext = {{OUT_MASK_BITS{1'b0}}, s3_mask_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
      pos_q       <= '0;
      mask_q      <= '0;
      sum_q       <= '0;
    end else if (en) begin
      s1_valid_q  <= pop_o;
      fin_valid_q <= s1_valid_q && s1_last_q;
      s3_valid_q  <= fin_valid_q;
      out_valid_o <= s3_valid_q;
      if (s1_valid_q) begin
        if (s1_last_q) begin
          pos_q  <= '0;
          mask_q <= '0;
          sum_q  <= '0;
        end else begin
          pos_q  <= pos_d;
          mask_q <= mask_d;
          sum_q  <= sum_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pop_o) begin
        s1_gt_q   <= (e_other_x > e_own_x);
        s1_diff_q <= (e_other_x > e_own_x) ? e_other_x - e_own_x : e_own_x - e_other_x;
        s1_last_q <= e_last;
        s1_tot_q  <= e_tot;
      end
      if (s1_valid_q && s1_last_q) begin
        fin_sum_q  <= sum_d;
        fin_mask_q <= mask_d;
        fin_tot_q  <= s1_tot_q;
      end
      s3_sum_q          <= fin_sum_q;
      s3_mask_q         <= fin_mask_q;
      s3_prod_q         <= RHS_BITS'(fin_tot_q) * RHS_BITS'(alpha_i);
      within_alpha_o    <= proximal;
      deficiency_mask_o <= proximal ? '0 : mask_ext[OUT_MASK_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/label_deficiency_mask.sv =====
// Top level of the label deficiency mask block.
// Each input transaction carries one label's counts in two histograms and both
// totals; last_label_i closes a comparison and yields one result transaction
// holding the deficiency mask (bits set where the other histogram's frequency is
// larger) and within_alpha_o (L1 distance of the normalized histograms below
// alpha, in which case the mask reads zero). Labels past MASK_BITS only add to
// the distance. Items are accepted one per cycle while the 4-entry queue has
// room; after its last label a result passes from the queue read into the
// difference stage, then the accumulator, the final totals-times-alpha
// multiply and the output register. alpha_threshold is unsigned Q2.16; the
// user must write it through the cfg port only while the block is idle, as
// the block itself does not enforce this.
`default_nettype none
module label_deficiency_mask #(
  parameter int MASK_BITS  = ldm_pkg::MASK_BITS_DEF,
  parameter int COUNT_BITS = ldm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ldm_pkg::ALPHA_BITS-1:0]    alpha_threshold_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [COUNT_BITS-1:0]             own_count_i,
  input  wire logic [COUNT_BITS-1:0]             other_count_i,
  input  wire logic [COUNT_BITS-1:0]             own_total_i,
  input  wire logic [COUNT_BITS-1:0]             other_total_i,
  input  wire logic                              last_label_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [ldm_pkg::OUT_MASK_BITS-1:0] deficiency_mask_o,
  output logic                                   within_alpha_o
);
  import ldm_pkg::*;

  localparam int PROD_BITS  = 2 * COUNT_BITS;
  localparam int ENTRY_BITS = 3 * PROD_BITS + 1;

  logic [ALPHA_BITS-1:0] alpha_q;
  logic [ENTRY_BITS-1:0] front_entry, queue_entry;
  logic                  push, pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      alpha_q <= alpha_threshold_i;
    end
  end

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !in_stall_o;

  ldm_front #(
    .COUNT_BITS (COUNT_BITS),
    .PROD_BITS  (PROD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_front (
    .own_count_i   (own_count_i),
    .other_count_i (other_count_i),
    .own_total_i   (own_total_i),
    .other_total_i (other_total_i),
    .last_label_i  (last_label_i),
    .entry_o       (front_entry)
  );

  ldm_queue #(
    .ENTRY_BITS (ENTRY_BITS)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_entry),
    .pop_i       (pop),
    .pop_data_o  (queue_entry),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  ldm_back #(
    .MASK_BITS  (MASK_BITS),
    .COUNT_BITS (COUNT_BITS),
    .PROD_BITS  (PROD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .alpha_i           (alpha_q),
    .entry_i           (queue_entry),
    .empty_i           (q_empty),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .deficiency_mask_o (deficiency_mask_o),
    .within_alpha_o    (within_alpha_o)
  );

  // A proximal comparison always reports an empty mask.
  a_within_clears_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && within_alpha_o) |-> (deficiency_mask_o == '0))
    else $error("within_alpha set with nonzero mask");

  // With a zero threshold nothing can be proximal.
  a_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (alpha_q == '0)) |-> !within_alpha_o)
    else $error("within_alpha set with zero alpha");

  // The back end never drains an empty queue.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !pop)
    else $error("pop from empty queue");

endmodule
`default_nettype wire
